### src/i2cmra_pkg.sv
// Package with the shared types, codes and defaults of the I2C register access master.
`default_nettype none
package i2cmra_pkg;

  localparam int MAX_BYTES_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_RESTART,
    PH_ADDR_W,
    PH_REG,
    PH_ADDR_R,
    PH_DATA,
    PH_RECV,
    PH_STOP
  } phase_t;

  typedef struct packed {
    op_t        operation;
    logic       sda_in;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [4:0] byte_count;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic       success;
  } result_t;

endpackage
`default_nettype wire

### src/i2cmra_core.sv
// Bus sequencer with its state registers and the write byte buffer.
`default_nettype none
module i2cmra_core import i2cmra_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire item_t   item,
  output result_t      res
);

  localparam int CntW  = $clog2(MAX_BYTES + 1);
  localparam int AddrW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CmpW  = (CntW > 5) ? CntW : 5;

  phase_t            phase, phase_next;
  logic [1:0]        tick_in_bit, tick_in_bit_next;
  logic [3:0]        bit_counter, bit_counter_next;
  logic [7:0]        shift_register, shift_register_next;
  logic [CntW-1:0]   byte_index, byte_index_next;
  logic [CntW-1:0]   transfer_length, transfer_length_next;
  logic              is_read, is_read_next;
  logic [6:0]        target_address, target_address_next;
  logic [7:0]        target_register, target_register_next;
  logic [CntW-1:0]   load_pointer, load_pointer_next;
  logic              nack_seen, nack_seen_next;

  logic [7:0]        write_buffer [0:MAX_BYTES-1];
  logic [7:0]        buffer_data;
  logic              load_we;

  logic              busy;
  logic [CmpW-1:0]   len_ext;
  logic [CmpW-1:0]   len_sat;
  logic [CntW:0]     index_inc;
  logic              ack_low;

  always_ff @(posedge clk) begin
    if (fire && load_we) begin
      write_buffer[load_pointer[AddrW-1:0]] <= item.write_data;
    end
    buffer_data <= write_buffer[byte_index[AddrW-1:0]];
  end

  always_comb begin
    phase_next           = phase;
    tick_in_bit_next     = tick_in_bit;
    bit_counter_next     = bit_counter;
    shift_register_next  = shift_register;
    byte_index_next      = byte_index;
    transfer_length_next = transfer_length;
    is_read_next         = is_read;
    target_address_next  = target_address;
    target_register_next = target_register;
    load_pointer_next    = load_pointer;
    nack_seen_next       = nack_seen;
    load_we              = 1'b0;
    res                  = '0;
    busy                 = (phase != PH_IDLE);
    len_ext              = CmpW'(item.byte_count);
    len_sat              = (len_ext > CmpW'(MAX_BYTES)) ? CmpW'(MAX_BYTES) : len_ext;
    index_inc            = {1'b0, byte_index} + 1'b1;

    case (item.operation)
      OP_TICK: begin
        if (busy) begin
          case (phase)
            PH_START, PH_RESTART: begin
              if (tick_in_bit < 2'd3) begin
                tick_in_bit_next = tick_in_bit + 2'd1;
              end else begin
                phase_next          = (phase == PH_START) ? PH_ADDR_W : PH_ADDR_R;
                shift_register_next = {target_address, (phase == PH_RESTART)};
                bit_counter_next    = '0;
                tick_in_bit_next    = '0;
              end
            end
            PH_ADDR_W, PH_REG, PH_ADDR_R, PH_DATA: begin
              if (!bit_counter[3]) begin
                if (tick_in_bit < 2'd2) begin
                  tick_in_bit_next = tick_in_bit + 2'd1;
                end else begin
                  shift_register_next = {shift_register[6:0], 1'b0};
                  bit_counter_next    = bit_counter + 4'd1;
                  tick_in_bit_next    = '0;
                end
              end else if (tick_in_bit == 2'd1) begin
                nack_seen_next   = nack_seen | item.sda_in;
                tick_in_bit_next = 2'd2;
              end else if (tick_in_bit == 2'd0) begin
                tick_in_bit_next = 2'd1;
              end else begin
                bit_counter_next = '0;
                tick_in_bit_next = '0;
                if (nack_seen) begin
                  phase_next = PH_STOP;
                end else if (phase == PH_ADDR_W) begin
                  phase_next          = PH_REG;
                  shift_register_next = target_register;
                end else if (phase == PH_REG && is_read) begin
                  phase_next = PH_RESTART;
                end else if (phase == PH_ADDR_R) begin
                  if (transfer_length != '0) begin
                    phase_next          = PH_RECV;
                    shift_register_next = '0;
                  end else begin
                    phase_next = PH_STOP;
                  end
                end else if (byte_index < transfer_length) begin
                  phase_next          = PH_DATA;
                  shift_register_next = buffer_data;
                  byte_index_next     = index_inc[CntW-1:0];
                end else begin
                  phase_next = PH_STOP;
                end
              end
            end
            PH_RECV: begin
              if (!bit_counter[3]) begin
                if (tick_in_bit == 2'd0) begin
                  shift_register_next = {shift_register[6:0], item.sda_in};
                  if (bit_counter == 4'd7) begin
                    res.read_valid = 1'b1;
                    res.read_data  = {shift_register[6:0], item.sda_in};
                  end
                  tick_in_bit_next = 2'd1;
                end else begin
                  bit_counter_next = bit_counter + 4'd1;
                  tick_in_bit_next = '0;
                end
              end else if (tick_in_bit < 2'd2) begin
                tick_in_bit_next = tick_in_bit + 2'd1;
              end else begin
                byte_index_next  = index_inc[CntW-1:0];
                bit_counter_next = '0;
                tick_in_bit_next = '0;
                if (index_inc < {1'b0, transfer_length}) begin
                  phase_next          = PH_RECV;
                  shift_register_next = '0;
                end else begin
                  phase_next = PH_STOP;
                end
              end
            end
            PH_STOP: begin
              if (tick_in_bit < 2'd2) begin
                tick_in_bit_next = tick_in_bit + 2'd1;
              end else begin
                phase_next       = PH_IDLE;
                bit_counter_next = '0;
                tick_in_bit_next = '0;
                res.done_res     = 1'b1;
                res.success      = !nack_seen;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_LOAD: begin
        if (!busy && load_pointer < CntW'(MAX_BYTES)) begin
          load_we           = 1'b1;
          load_pointer_next = load_pointer + 1'b1;
        end
      end
      default: begin
        if (!busy) begin
          transfer_length_next = len_sat[CntW-1:0];
          target_address_next  = item.device_address;
          target_register_next = item.register_address;
          is_read_next         = (item.operation == OP_READ);
          byte_index_next      = '0;
          load_pointer_next    = '0;
          nack_seen_next       = 1'b0;
          shift_register_next  = '0;
          phase_next           = PH_START;
          bit_counter_next     = '0;
          tick_in_bit_next     = '0;
        end
      end
    endcase

    ack_low = ({1'b0, byte_index_next} + 1'b1) < {1'b0, transfer_length_next};
    res.busy_res = (phase_next != PH_IDLE);
    case (phase_next)
      PH_START, PH_RESTART: begin
        res.scl_out = (tick_in_bit_next == 2'd1) || (tick_in_bit_next == 2'd2) ||
                      (tick_in_bit_next == 2'd0 && phase_next == PH_START);
        res.sda_out = (tick_in_bit_next < 2'd2);
      end
      PH_ADDR_W, PH_REG, PH_ADDR_R, PH_DATA: begin
        res.scl_out = (tick_in_bit_next == 2'd1);
        res.sda_out = bit_counter_next[3] ? 1'b1 : shift_register_next[7];
      end
      PH_RECV: begin
        if (!bit_counter_next[3]) begin
          res.scl_out = (tick_in_bit_next == 2'd0);
          res.sda_out = 1'b1;
        end else begin
          res.scl_out = (tick_in_bit_next == 2'd1);
          res.sda_out = !ack_low;
        end
      end
      PH_STOP: begin
        res.scl_out = (tick_in_bit_next >= 2'd1);
        res.sda_out = (tick_in_bit_next == 2'd2);
      end
      default: begin
        res.scl_out = 1'b1;
        res.sda_out = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_in_bit     <= '0;
      bit_counter     <= '0;
      shift_register  <= '0;
      byte_index      <= '0;
      transfer_length <= '0;
      is_read         <= 1'b0;
      target_address  <= '0;
      target_register <= '0;
      load_pointer    <= '0;
      nack_seen       <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      tick_in_bit     <= tick_in_bit_next;
      bit_counter     <= bit_counter_next;
      shift_register  <= shift_register_next;
      byte_index      <= byte_index_next;
      transfer_length <= transfer_length_next;
      is_read         <= is_read_next;
      target_address  <= target_address_next;
      target_register <= target_register_next;
      load_pointer    <= load_pointer_next;
      nack_seen       <= nack_seen_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_in_bit == 2'd0 && bit_counter == 4'd0))
    else $error("Sequencer idle with a bit in progress.");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_counter <= 4'd8)
    else $error("Bit counter beyond the acknowledge slot.");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (byte_index <= transfer_length) && (transfer_length <= CntW'(MAX_BYTES)))
    else $error("Byte index beyond the transfer length.");

endmodule
`default_nettype wire

### src/i2c_master_register_access_top.sv
// Top level of the I2C register access master: input register, sequencer and result register.
// Words wait in the input register; each result is captured in the result register.
// Throughput: one word per cycle unless out_ready stalls; each word gives exactly one result.
// Each tick word advances the bus by one delay period; commands while busy are dropped.
// Reset: synchronous, active high; the sequencer returns to idle at once, no clearing pass.
// The write buffer holds no value after reset until bytes are loaded into it.
`default_nettype none
module i2c_master_register_access_top import i2cmra_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] operation,
  input  wire logic       sda_in,
  input  wire logic [6:0] device_address,
  input  wire logic [7:0] register_address,
  input  wire logic [4:0] byte_count,
  input  wire logic [7:0] write_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl_out,
  output logic            sda_out,
  output logic            busy_res,
  output logic            read_valid,
  output logic [7:0]      read_data,
  output logic            done_res,
  output logic            success
);

  logic    hold_valid;
  item_t   hold_item;
  logic    fire;
  result_t res_comb;
  result_t res_q;

  assign fire     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item.operation        <= op_t'(operation);
      hold_item.sda_in           <= sda_in;
      hold_item.device_address   <= device_address;
      hold_item.register_address <= register_address;
      hold_item.byte_count       <= byte_count;
      hold_item.write_data       <= write_data;
    end
  end

  i2cmra_core #(
    .MAX_BYTES(MAX_BYTES)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .item(hold_item),
    .res (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_comb;
    end
  end

  assign scl_out    = res_q.scl_out;
  assign sda_out    = res_q.sda_out;
  assign busy_res   = res_q.busy_res;
  assign read_valid = res_q.read_valid;
  assign read_data  = res_q.read_data;
  assign done_res   = res_q.done_res;
  assign success    = res_q.success;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && scl_out && sda_out))
    else $error("Transaction finished while the bus is still held.");

  a_success_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && success) |-> done_res)
    else $error("Success reported without a finished transaction.");

  a_read_in_flight: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_valid) |-> (busy_res && !done_res))
    else $error("Received byte reported outside a read.");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !read_valid) |-> (read_data == 8'd0))
    else $error("Read data not cleared without a received byte.");

endmodule
`default_nettype wire
